// ===== rtl/ffba_pkg.sv =====
// package for the first-fit block allocator
// entry type, cell operation codes, status codes and controller states; no dependencies
`default_nettype none
package ffba_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SIZE_W = 17;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SET_USED,
    CELL_MARK_FREE,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_MERGE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NULLFREE = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_MERGE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic alloc_hit;
    logic free_hit;
    logic pair_hit;
  } cell_flags_t;

endpackage
`default_nettype wire

// ===== rtl/ffba_cell.sv =====
// one table entry of the allocator chain with its compare logic
// depends on ffba_pkg
`default_nettype none
module ffba_cell #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter bit          RST_VALID    = 1'b0,
  parameter int unsigned RST_SIZE     = 0
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ffba_pkg::cell_op_e                 op_i,
  input  ffba_pkg::entry_t                   load_i,
  input  ffba_pkg::entry_t                   left_i,
  input  ffba_pkg::entry_t                   right_i,
  input  wire  [ffba_pkg::SIZE_W-1:0]        req_size_i,
  input  wire  [ffba_pkg::ADDR_W-1:0]        req_addr_i,
  output ffba_pkg::entry_t                   entry_o,
  output ffba_pkg::cell_flags_t              flags_o
);

  ffba_pkg::entry_t entry_q, entry_d;
  logic [ffba_pkg::SIZE_W-1:0] merged_size;
  logic [ffba_pkg::SIZE_W-1:0] payload_pos;

  assign merged_size = entry_q.size + right_i.size + ffba_pkg::SIZE_W'(HEADER_BYTES);
  assign payload_pos = {1'b0, entry_q.start} + ffba_pkg::SIZE_W'(HEADER_BYTES);

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      ffba_pkg::CELL_HOLD:       entry_d = entry_q;
      ffba_pkg::CELL_SET_USED: begin
        entry_d.free = 1'b0;
        entry_d.size = req_size_i;
      end
      ffba_pkg::CELL_MARK_FREE:  entry_d.free = 1'b1;
      ffba_pkg::CELL_LOAD:       entry_d = load_i;
      ffba_pkg::CELL_FROM_LEFT:  entry_d = left_i;
      ffba_pkg::CELL_FROM_RIGHT: entry_d = right_i;
      ffba_pkg::CELL_MERGE:      entry_d.size = merged_size;
      default:                   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.valid <= RST_VALID;
      entry_q.free  <= RST_VALID;
      entry_q.start <= '0;
      entry_q.size  <= ffba_pkg::SIZE_W'(RST_SIZE);
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o           = entry_q;
  assign flags_o.alloc_hit = entry_q.valid && entry_q.free && (entry_q.size >= req_size_i);
  assign flags_o.free_hit  = entry_q.valid && !entry_q.free &&
                             (payload_pos == {1'b0, req_addr_i});
  assign flags_o.pair_hit  = entry_q.valid && entry_q.free && right_i.valid && right_i.free;

endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator: cell chain and sequencer
// depends on ffba_pkg and ffba_cell
// allocate searches, then fits or splits; free searches, marks free and merges
// free neighbours (at most two); null free goes to the result; one item at a time, next
// input taken once the output is loaded; search, split, merge act on all cells at once
// reset: table holds one free block spanning the heap less one header
`default_nettype none
module first_fit_block_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // alloc_size[16:0], free_address[32:17], zero pad
  input  wire         s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // payload_address[15:0], status[17:16], zero pad
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = ffba_pkg::ADDR_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;

  ffba_pkg::state_e state_q, state_d;

  logic          op_q, op_d;
  logic [SW-1:0] size_q, size_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] count_q, count_d;
  logic [MAX_BLOCKS-1:0] sel_q, sel_d;
  logic          found_q, found_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  ffba_pkg::status_e res_st_q, res_st_d;
  logic          out_valid_q, out_valid_d;
  logic [23:0]   out_data_q, out_data_d;

  ffba_pkg::entry_t      entries [MAX_BLOCKS];
  ffba_pkg::cell_flags_t flags   [MAX_BLOCKS];
  ffba_pkg::cell_op_e    ops     [MAX_BLOCKS];
  ffba_pkg::entry_t      load_entry;

  logic [MAX_BLOCKS-1:0] hit_vec, pair_vec, pair_first, above_sel, above_pair;
  ffba_pkg::entry_t      sel_entry;
  logic [SW:0]           need_split;
  logic                  in_xfer, out_load;

  localparam ffba_pkg::entry_t EMPTY = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_pkg::entry_t left_e, right_e;
    if (k == 0) begin : g_l0
      assign left_e = EMPTY;
    end else begin : g_l
      assign left_e = entries[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_rn
      assign right_e = EMPTY;
    end else begin : g_r
      assign right_e = entries[k+1];
    end
    ffba_cell #(
      .HEADER_BYTES(HEADER_BYTES),
      .RST_VALID   (k == 0),
      .RST_SIZE    ((k == 0) ? (HEAP_BYTES - HEADER_BYTES) : 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (ops[k]),
      .load_i    (load_entry),
      .left_i    (left_e),
      .right_i   (right_e),
      .req_size_i(size_q),
      .req_addr_i(addr_q),
      .entry_o   (entries[k]),
      .flags_o   (flags[k])
    );
    assign hit_vec[k]  = op_q ? flags[k].free_hit : flags[k].alloc_hit;
    assign pair_vec[k] = flags[k].pair_hit;
  end

  assign above_sel  = ~(sel_q | (sel_q - MAX_BLOCKS'(1)));
  assign pair_first = pair_vec & (~pair_vec + MAX_BLOCKS'(1));
  assign above_pair = ~(pair_first | (pair_first - MAX_BLOCKS'(1)));

  always_comb begin
    sel_entry = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      sel_entry = sel_entry | (entries[k] & {$bits(ffba_pkg::entry_t){sel_q[k]}});
    end
  end

  assign need_split = {1'b0, size_q} + (SW + 1)'(HEADER_BYTES);

  always_comb begin
    load_entry.valid = 1'b1;
    load_entry.free  = 1'b1;
    load_entry.start = sel_entry.start + AW'(HEADER_BYTES) + size_q[AW-1:0];
    load_entry.size  = sel_entry.size - size_q - SW'(HEADER_BYTES);
  end

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ffba_pkg::S_RESULT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    size_d     = size_q;
    addr_d     = addr_q;
    count_d    = count_q;
    sel_d      = sel_q;
    found_d    = found_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      ops[k] = ffba_pkg::CELL_HOLD;
    end
    s_axis_tready = (state_q == ffba_pkg::S_IDLE);
    case (state_q)
      ffba_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_d       = s_axis_tuser;
          size_d     = s_axis_tdata[16:0];
          addr_d     = s_axis_tdata[32:17];
          res_addr_d = '0;
          if (s_axis_tuser && (s_axis_tdata[32:17] == '0)) begin
            res_st_d = ffba_pkg::ST_NULLFREE;
            state_d  = ffba_pkg::S_RESULT;
          end else begin
            state_d = ffba_pkg::S_SEARCH;
          end
        end
      end
      ffba_pkg::S_SEARCH: begin
        sel_d   = hit_vec & (~hit_vec + MAX_BLOCKS'(1));
        found_d = |hit_vec;
        state_d = ffba_pkg::S_APPLY;
      end
      ffba_pkg::S_APPLY: begin
        state_d = ffba_pkg::S_RESULT;
        if (!found_q) begin
          res_st_d = op_q ? ffba_pkg::ST_UNKNOWN : ffba_pkg::ST_NOSPACE;
        end else if (op_q) begin
          res_st_d = ffba_pkg::ST_OK;
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (sel_q[k]) ops[k] = ffba_pkg::CELL_MARK_FREE;
          end
          state_d = ffba_pkg::S_MERGE;
        end else if (sel_entry.size == size_q) begin
          res_st_d   = ffba_pkg::ST_OK;
          res_addr_d = sel_entry.start + AW'(HEADER_BYTES);
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (sel_q[k]) ops[k] = ffba_pkg::CELL_SET_USED;
          end
        end else if (({1'b0, sel_entry.size} > need_split) &&
                     (count_q != CW'(MAX_BLOCKS))) begin
          res_st_d   = ffba_pkg::ST_OK;
          res_addr_d = sel_entry.start + AW'(HEADER_BYTES);
          count_d    = count_q + CW'(1);
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (sel_q[k]) begin
              ops[k] = ffba_pkg::CELL_SET_USED;
            end else if (k > 0 && sel_q[(k > 0) ? k - 1 : 0]) begin
              ops[k] = ffba_pkg::CELL_LOAD;
            end else if (above_sel[k]) begin
              ops[k] = ffba_pkg::CELL_FROM_LEFT;
            end
          end
        end else begin
          res_st_d = ffba_pkg::ST_NOSPACE;
        end
      end
      ffba_pkg::S_MERGE: begin
        if (|pair_vec) begin
          count_d = count_q - CW'(1);
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (pair_first[k]) begin
              ops[k] = ffba_pkg::CELL_MERGE;
            end else if (above_pair[k]) begin
              ops[k] = ffba_pkg::CELL_FROM_RIGHT;
            end
          end
        end else begin
          state_d = ffba_pkg::S_RESULT;
        end
      end
      ffba_pkg::S_RESULT: begin
        if (out_load) state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'b0, res_st_q, res_addr_q};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::S_IDLE;
      count_q     <= CW'(1);
      found_q     <= 1'b0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      found_q     <= found_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    size_q     <= size_d;
    addr_q     <= addr_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/ffba_checker.sv =====
// port-level checks for the first-fit block allocator, bound to the top level
// depends on ffba_pkg and first_fit_block_allocator
`default_nettype none
module ffba_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // failed or free results carry a null address
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[17:16] != ffba_pkg::ST_OK) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("failure with nonzero address");

  // padding stays zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
    else $error("padding bits set");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// ===== tb/tb_first_fit_block_allocator.sv =====
// testbench for first_fit_block_allocator: directed and random allocate/free traffic
// checked against a behavioral copy of the block table; depends on ffba_pkg and the rtl
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;

  localparam int unsigned HEAP   = 65536;
  localparam int unsigned HDR    = 16;
  localparam int unsigned NBLK   = 64;
  localparam bit          OP_ALLOC = 1'b0;
  localparam bit          OP_FREE  = 1'b1;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0]       addr;
    ffba_pkg::status_e status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  logic [15:0] tbl_start [NBLK];
  logic [16:0] tbl_size  [NBLK];
  logic        tbl_free  [NBLK];
  int          tbl_count;

  answer_t     answer_q[$];
  logic [15:0] live_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          hold_off = 0;

  first_fit_block_allocator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void table_reset();
    for (int k = 0; k < NBLK; k++) begin
      tbl_start[k] = '0;
      tbl_size[k] = '0;
      tbl_free[k] = 1'b0;
    end
    tbl_size[0] = 17'(HEAP - HDR);
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic void merge_free_neighbors();
    int i;
    i = 0;
    while (i + 1 < tbl_count) begin
      if (tbl_free[i] && tbl_free[i+1]) begin
        tbl_size[i] = 17'(tbl_size[i] + tbl_size[i+1] + HDR);
        for (int k = i + 1; k + 1 < tbl_count; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_size[k] = tbl_size[k+1];
          tbl_free[k] = tbl_free[k+1];
        end
        tbl_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic answer_t predict_answer(bit op, logic [16:0] n, logic [15:0] a);
    answer_t r;
    int i;
    r.addr = '0;
    r.status = ffba_pkg::ST_UNKNOWN;
    if (op == OP_ALLOC) begin
      for (i = 0; i < tbl_count; i++)
        if (tbl_free[i] && tbl_size[i] >= n) break;
      r.status = ffba_pkg::ST_NOSPACE;
      if (i < tbl_count) begin
        if (tbl_size[i] == n) begin
          tbl_free[i] = 1'b0;
          r.status = ffba_pkg::ST_OK;
        end else if (int'(tbl_size[i]) > int'(n) + HDR && tbl_count < NBLK) begin
          for (int k = tbl_count; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_free[k] = tbl_free[k-1];
          end
          tbl_start[i+1] = 16'(tbl_start[i] + HDR + n);
          tbl_size[i+1] = 17'(tbl_size[i] - n - HDR);
          tbl_free[i+1] = 1'b1;
          tbl_size[i] = n;
          tbl_free[i] = 1'b0;
          tbl_count++;
          r.status = ffba_pkg::ST_OK;
        end
        if (r.status == ffba_pkg::ST_OK) r.addr = 16'(tbl_start[i] + HDR);
      end
    end else if (a == 16'd0) begin
      r.status = ffba_pkg::ST_NULLFREE;
    end else begin
      for (i = 0; i < tbl_count; i++) begin
        if (!tbl_free[i] && 17'(tbl_start[i]) + HDR == 17'(a)) begin
          tbl_free[i] = 1'b1;
          merge_free_neighbors();
          r.status = ffba_pkg::ST_OK;
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(bit op, logic [16:0] n, logic [15:0] a);
    answer_t r;
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, a, n};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_answer(op, n, a);
    answer_q.push_back(r);
    if (op == OP_ALLOC && r.status == ffba_pkg::ST_OK) live_q.push_back(r.addr);
  endtask

  task automatic free_random_live();
    int j;
    logic [15:0] a;
    j = $urandom_range(0, live_q.size() - 1);
    a = live_q[j];
    live_q.delete(j);
    send_request(OP_FREE, 17'd0, a);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OP_FREE, 17'd0, 16'd0);
    send_request(OP_FREE, 17'd0, 16'hFFFF);
    send_request(OP_FREE, 17'd0, 16'd16);
    send_request(OP_ALLOC, 17'd0, 16'hFFFF);
    send_request(OP_ALLOC, 17'd100, 16'd0);
    send_request(OP_ALLOC, 17'h1FFFF, 16'd0);
    send_request(OP_ALLOC, 17'd65536, 16'd0);
    send_request(OP_FREE, 17'h1FFFF, 16'd16);
    send_request(OP_FREE, 17'd0, 16'd16);
    send_request(OP_FREE, 17'd0, 16'd32);
    send_request(OP_ALLOC, 17'd200, 16'd0);
    send_request(OP_ALLOC, 17'd200, 16'd0);
    send_request(OP_FREE, 17'd0, 16'd16);
    // too small to split, first fit stops there
    send_request(OP_ALLOC, 17'd190, 16'd0);
    send_request(OP_ALLOC, 17'd200, 16'd0);
    send_request(OP_FREE, 17'd0, 16'd232);
    send_request(OP_FREE, 17'd0, 16'd232);
    send_request(OP_FREE, 17'd0, 16'd16);
    // exact fit of the whole heap, then nothing left
    send_request(OP_ALLOC, 17'd65520, 16'd0);
    send_request(OP_ALLOC, 17'd0, 16'd0);
    send_request(OP_FREE, 17'd0, 16'd16);
    live_q.delete();
    drain();
  endtask

  task automatic test_table_full();
    for (int k = 0; k < 70; k++) send_request(OP_ALLOC, 17'($urandom_range(0, 8)), 16'd0);
    send_request(OP_ALLOC, 17'd1000, 16'd0);
    while (live_q.size() != 0) free_random_live();
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int k = 0; k < 20; k++) send_request(OP_ALLOC, 17'($urandom_range(1, 64)), 16'd0);
    while (live_q.size() != 0) free_random_live();
    drain();
  endtask

  task automatic test_random(int count);
    int pick;
    logic [16:0] n;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: n = 17'($urandom_range(0, 32));
          1: n = 17'($urandom_range(0, 1024));
          2: n = 17'($urandom_range(0, 8192));
          default: n = 17'($urandom);
        endcase
        send_request(OP_ALLOC, n, 16'd0);
      end else if (pick < 88 && live_q.size() != 0) begin
        free_random_live();
      end else if (pick < 92) begin
        send_request(OP_FREE, 17'($urandom), 16'd0);
      end else begin
        send_request(OP_FREE, 17'($urandom), 16'($urandom));
      end
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = answer_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_r.addr) begin
          $display("%0t payload_address mismatch: expected %h, actual %h",
                   $time, exp_r.addr, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[17:16] !== exp_r.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, m_axis_tdata[17:16]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    table_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(1650);
    if (answer_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
